FILE: rtl/lnbt_pkg.sv
// Shared types, widths, opcodes and sigmoid table functions for the logistic neuron trainer.
`default_nettype none

package lnbt_pkg;

  // Default sizes
  localparam int unsigned FEATURES_DEF  = 4;
  localparam int unsigned SIG_DEPTH_DEF = 256;
  localparam int unsigned MAX_FEATURES  = 4;

  // Field and datapath widths
  localparam int unsigned W_W    = 24;  // weight Q8.16
  localparam int unsigned X_W    = 16;  // feature Q4.12
  localparam int unsigned P_W    = 17;  // probability Q1.16
  localparam int unsigned E_W    = 18;  // residual, signed
  localparam int unsigned D_W    = 18;  // delta, signed Q2.16
  localparam int unsigned PROD_W = 40;  // w*x in Q.28
  localparam int unsigned SUM_W  = 42;  // sum of up to four products
  localparam int unsigned Z_W    = 32;  // saturated dot product
  localparam int unsigned ACC_W  = 48;  // gradient accumulator Q20.28

  // Opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_INFER = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [P_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [63:0]    EINV_Q32 = 64'd1580030169;

  // Per-lane update strobes from the sequencer
  typedef struct packed {
    logic acc_en;    // add x*delta into the accumulator
    logic apply_en;  // fold accumulator into weight, clear accumulator
  } lane_ctrl_t;

  // Unsigned 64-bit quotient by shift and subtract (elaboration only)
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid of a non-negative Q.32 value, Q1.16 result (elaboration only)
  function automatic logic [P_W-1:0] sig_pos(input logic [63:0] tq);
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        r;
    logic [63:0]        d;
    logic [63:0]        q;
    logic signed [63:0] sum;
    n    = tq >> 32;
    f    = {32'd0, tq[31:0]};
    term = 64'd1 << 32;
    sum  = 64'sd1 <<< 32;
    // Taylor series of e^-f
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > (64'sd1 <<< 32)) begin
      sum = 64'sd1 <<< 32;
    end
    r = 64'(sum);
    // integer part: repeated products with e^-1
    for (int k = 0; k < 8; k++) begin
      if (64'(k) < n) begin
        r = (r * EINV_Q32 + (64'd1 << 31)) >> 32;
      end
    end
    d = (64'd1 << 32) + r;
    q = udiv64((64'd1 << 48) + (d >> 1), d);
    return q[P_W-1:0];
  endfunction

  // Table entry for a bin centre in Q.32
  function automatic logic [P_W-1:0] sig_entry(input logic signed [63:0] c);
    logic [P_W-1:0] v;
    if (c >= 0) begin
      v = sig_pos(64'(c));
    end else begin
      v = ONE_Q16 - sig_pos(64'(-c));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lnbt_lane.sv
// One weight lane: weight and accumulator registers, w*x product, gradient update and apply.
`default_nettype none

module lnbt_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic signed [lnbt_pkg::X_W-1:0]      x_i,
  input  wire logic                                 load_en_i,
  input  wire logic signed [lnbt_pkg::W_W-1:0]      load_value_i,
  input  wire lnbt_pkg::lane_ctrl_t                 ctrl_i,
  input  wire logic signed [lnbt_pkg::D_W-1:0]      delta_i,
  output logic signed [lnbt_pkg::PROD_W-1:0]        prod_o
);
  import lnbt_pkg::*;

  logic signed [W_W-1:0]    weight_q, weight_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [X_W+D_W-1:0] step;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [W_W+13-1:0] w_sum;
  logic signed [W_W-1:0]    w_sat;

  // product register for the dot product
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(weight_q) * PROD_W'(x_i);
  end
  assign prod_o = prod_q;

  // accumulate x*delta, saturating at 48 bits
  always_comb begin
    step    = (X_W+D_W)'(x_i) * (X_W+D_W)'(delta_i);
    acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(step);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // weight plus accumulator / 2^12, saturating at 24 bits
  always_comb begin
    acc_shr = acc_q >>> 12;
    w_sum   = (W_W+13)'(weight_q) + acc_shr[W_W+13-1:0];
    if (w_sum > (W_W+13)'(signed'({1'b0, {(W_W-1){1'b1}}}))) begin
      w_sat = {1'b0, {(W_W-1){1'b1}}};
    end else if (w_sum < (W_W+13)'(signed'({1'b1, {(W_W-1){1'b0}}}))) begin
      w_sat = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      w_sat = w_sum[W_W-1:0];
    end
  end

  // state update
  always_comb begin
    weight_d = weight_q;
    acc_d    = acc_q;
    if (load_en_i) begin
      weight_d = load_value_i;
    end
    if (ctrl_i.acc_en) begin
      acc_d = acc_sat;
    end
    if (ctrl_i.apply_en) begin
      weight_d = w_sat;
      acc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      acc_q    <= '0;
    end else begin
      weight_q <= weight_d;
      acc_q    <= acc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lnbt_merge.sv
// Merge stage: sums lane products, saturates, scales to a table index and looks up the sigmoid.
`default_nettype none

module lnbt_merge #(
  parameter int unsigned FEATURES            = lnbt_pkg::FEATURES_DEF,
  parameter int unsigned SIGMOID_TABLE_DEPTH = lnbt_pkg::SIG_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic signed [lnbt_pkg::PROD_W-1:0]   prod_i [FEATURES],
  output logic [lnbt_pkg::P_W-1:0]                  pred_o
);
  import lnbt_pkg::*;

  localparam int unsigned IDX_W = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;
  localparam int unsigned DEP_W = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int unsigned SCL_W = Z_W + DEP_W;

  logic signed [SUM_W-1:0] sum;
  logic signed [Z_W-1:0]   z_d, z_q;
  logic [Z_W-1:0]          biased;
  logic [SCL_W-1:0]        scaled;
  logic [IDX_W-1:0]        idx_q;
  logic [P_W-1:0]          pred_q;
  logic [P_W-1:0]          sig_tab [SIGMOID_TABLE_DEPTH];

  // constant sigmoid table, one entry per bin centre
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0]        SPAN   = (64'(2 * g + 1) << 35) / 64'(SIGMOID_TABLE_DEPTH);
    localparam logic signed [63:0] CENTER = $signed(SPAN) - (64'sd1 <<< 35);
    localparam logic [P_W-1:0]     ENTRY  = sig_entry(CENTER);
    assign sig_tab[g] = ENTRY;
  end

  // add lane products and clamp to [-8, 8)
  always_comb begin
    sum = '0;
    for (int i = 0; i < FEATURES; i++) begin
      sum = sum + SUM_W'(prod_i[i]);
    end
    if (sum > SUM_W'(signed'({1'b0, {(Z_W-1){1'b1}}}))) begin
      z_d = {1'b0, {(Z_W-1){1'b1}}};
    end else if (sum < SUM_W'(signed'({1'b1, {(Z_W-1){1'b0}}}))) begin
      z_d = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      z_d = sum[Z_W-1:0];
    end
  end

  // offset to unsigned and scale by table depth
  always_comb begin
    biased = {~z_q[Z_W-1], z_q[Z_W-2:0]};
    scaled = SCL_W'(biased) * SCL_W'(SIGMOID_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    idx_q  <= scaled[Z_W +: IDX_W];
    pred_q <= sig_tab[idx_q];
  end

  assign pred_o = pred_q;

endmodule

`default_nettype wire

FILE: rtl/lnbt_grad.sv
// Error path: residual, sigmoid derivative and delta, one multiply per stage.
`default_nettype none

module lnbt_grad (
  input  wire logic                               clk_i,
  input  wire logic [lnbt_pkg::P_W-1:0]           pred_i,
  input  wire logic [lnbt_pkg::P_W-1:0]           tgt_i,
  output logic signed [lnbt_pkg::E_W-1:0]         err_o,
  output logic signed [lnbt_pkg::D_W-1:0]         delta_o
);
  import lnbt_pkg::*;

  logic [2*P_W-1:0]       dprod;
  logic [P_W-1:0]         deriv_q;
  logic signed [E_W-1:0]  err_q;
  logic signed [E_W+D_W-1:0] dm;
  logic signed [D_W-1:0]  delta_q;

  // p*(1-p) and derivative times residual
  always_comb begin
    dprod = (2*P_W)'(pred_i) * (2*P_W)'(ONE_Q16 - pred_i);
    dm    = (E_W+D_W)'($signed({1'b0, deriv_q})) * (E_W+D_W)'(err_q);
  end

  always_ff @(posedge clk_i) begin
    deriv_q <= dprod[16 +: P_W];
    err_q   <= $signed({1'b0, tgt_i}) - $signed({1'b0, pred_i});
    delta_q <= dm[16 +: D_W];
  end

  assign err_o   = err_q;
  assign delta_o = delta_q;

endmodule

`default_nettype wire

FILE: rtl/logistic_neuron_batch_trainer_unit.sv
// Top level of the logistic neuron batch trainer: sequencer, lanes, merge, error path, output.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries items with an opcode:
// load writes one weight, train predicts and accumulates a gradient, infer only
// predicts. Every item gives exactly one result on the output channel
// (out_valid_o/out_ready_i): prediction, residual and the weights_applied flag.
// Items are handled one at a time; in_ready_o is high while the sequencer idles.
// Steps per item, each a registered sequencer state: lane multiply, sum,
// table index scaling, table read, derivative, delta and lane accumulate;
// infer stops after the table read, and load or an unknown opcode goes
// straight to the result. A train item with batch_last adds the weight
// apply step, which follows the result's hand-off to the output register.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following item completes its
// work and holds in the final step until the output register frees; the
// weights are updated only after its result has moved into the output register.
// Reset clears weights, accumulators and the handshake state; the sigmoid
// table is constant logic, so no fill time follows reset.
`default_nettype none

module logistic_neuron_batch_trainer_unit #(
  parameter int unsigned FEATURES            = lnbt_pkg::FEATURES_DEF,
  parameter int unsigned SIGMOID_TABLE_DEPTH = lnbt_pkg::SIG_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic signed [15:0]                 feature_0_i,
  input  wire logic signed [15:0]                 feature_1_i,
  input  wire logic signed [15:0]                 feature_2_i,
  input  wire logic signed [15:0]                 feature_3_i,
  input  wire logic [16:0]                        target_i,
  input  wire logic                               batch_last_i,
  input  wire logic [1:0]                         weight_slot_i,
  input  wire logic signed [23:0]                 weight_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [16:0]                             prediction_o,
  output logic signed [17:0]                      residual_o,
  output logic                                    weights_applied_o
);
  import lnbt_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_IDX   = 4'd3;
  localparam logic [3:0] ST_LUT   = 4'd4;
  localparam logic [3:0] ST_DERIV = 4'd5;
  localparam logic [3:0] ST_DELTA = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_APPLY = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]                state_q, state_d;
  logic                      accept;
  logic                      out_load;
  logic [1:0]                op_q;
  logic                      last_q;
  logic [P_W-1:0]            tgt_q;
  logic signed [X_W-1:0]     feat_w [MAX_FEATURES];
  logic signed [X_W-1:0]     x_q    [FEATURES];
  logic signed [PROD_W-1:0]  prod_w [FEATURES];
  logic [P_W-1:0]            pred_w;
  logic signed [E_W-1:0]     err_w;
  logic signed [D_W-1:0]     delta_w;
  lane_ctrl_t                lane_ctrl;
  logic                      out_valid_q;
  logic [P_W-1:0]            out_pred_q;
  logic signed [E_W-1:0]     out_resid_q;
  logic                      out_applied_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign feat_w[0] = feature_0_i;
  assign feat_w[1] = feature_1_i;
  assign feat_w[2] = feature_2_i;
  assign feat_w[3] = feature_3_i;

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      last_q <= batch_last_i;
      tgt_q  <= (target_i > ONE_Q16) ? ONE_Q16 : target_i;
      for (int i = 0; i < FEATURES; i++) begin
        x_q[i] <= feat_w[i];
      end
    end
  end

  // sequencer; the weight apply step runs after the result is handed off
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_TRAIN || opcode_i == OP_INFER) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_IDX;
      ST_IDX:   state_d = ST_LUT;
      ST_LUT:   state_d = (op_q == OP_TRAIN) ? ST_DERIV : ST_DONE;
      ST_DERIV: state_d = ST_DELTA;
      ST_DELTA: state_d = ST_ACC;
      ST_ACC:   state_d = ST_DONE;
      ST_APPLY: state_d = ST_IDLE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ((op_q == OP_TRAIN) && last_q) ? ST_APPLY : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign lane_ctrl.acc_en   = (state_q == ST_ACC);
  assign lane_ctrl.apply_en = (state_q == ST_APPLY);

  // weight lanes
  for (genvar g = 0; g < FEATURES; g++) begin : g_lane
    lnbt_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .x_i          (x_q[g]),
      .load_en_i    (accept && (opcode_i == OP_LOAD) && (32'(weight_slot_i) == g)),
      .load_value_i (weight_value_i),
      .ctrl_i       (lane_ctrl),
      .delta_i      (delta_w),
      .prod_o       (prod_w[g])
    );
  end

  lnbt_merge #(
    .FEATURES            (FEATURES),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_merge (
    .clk_i  (clk_i),
    .prod_i (prod_w),
    .pred_o (pred_w)
  );

  lnbt_grad u_grad (
    .clk_i   (clk_i),
    .pred_i  (pred_w),
    .tgt_i   (tgt_q),
    .err_o   (err_w),
    .delta_o (delta_w)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pred_q    <= (op_q == OP_TRAIN || op_q == OP_INFER) ? pred_w : '0;
      out_resid_q   <= (op_q == OP_TRAIN) ? err_w : '0;
      out_applied_q <= (op_q == OP_TRAIN) && last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign prediction_o      = out_pred_q;
  assign residual_o        = out_resid_q;
  assign weights_applied_o = out_applied_q;

endmodule

`default_nettype wire

FILE: rtl/lnbt_checker.sv
// Port-level checker for the logistic neuron trainer, bound to the top level.
`default_nettype none

module lnbt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [16:0]        prediction_o,
  input wire logic signed [17:0] residual_o,
  input wire logic               weights_applied_o
);

  // one item in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item still in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prediction_o)
      && $stable(residual_o) && $stable(weights_applied_o))
    else $error("stalled result changed");

  // prediction never above one
  a_pred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> prediction_o <= 17'd65536)
    else $error("prediction out of range");

  // residual within plus or minus one
  a_resid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (residual_o <= 18'sd65536) && (residual_o >= -18'sd65536))
    else $error("residual out of range");

  // an applied batch always reports a result with a nonzero prediction
  a_applied_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (prediction_o == 17'd0) |-> !weights_applied_o)
    else $error("weights applied on a result without prediction");

endmodule

bind logistic_neuron_batch_trainer_unit lnbt_checker u_lnbt_checker (.*);

`default_nettype wire

FILE: test/tb_logistic_neuron_batch_trainer_unit.sv
// Self-checking testbench for the logistic neuron batch trainer unit.
module tb_logistic_neuron_batch_trainer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lnbt_pkg::*;

  localparam int unsigned FEATURES    = FEATURES_DEF;
  localparam int unsigned SIG_DEPTH   = SIG_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          PHASE_ITEMS = 325;

  // One input item, as the sender presents it
  typedef struct {
    logic [1:0]         opcode;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic [16:0]        target;
    logic               batch_last;
    logic [1:0]         weight_slot;
    logic signed [23:0] weight_value;
  } neuron_item_t;

  // One result item
  typedef struct packed {
    logic [16:0]        prediction;
    logic signed [17:0] residual;
    logic               applied;
  } neuron_outcome_t;

  // Shadow neuron: tracks weights and gradient sums, queues the outcome of each item
  class neuron_mirror;
    localparam longint Z_HI   = 64'sd2147483647;
    localparam longint Z_LO   = -64'sd2147483648;
    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -64'sd140737488355328;
    localparam longint W_HI   = 64'sd8388607;
    localparam longint W_LO   = -64'sd8388608;
    localparam bit [63:0] EXP_NEG1_Q32 = 64'd1580030169;

    longint          weight_q [4];
    longint          grad_acc [4];
    logic [16:0]     sigmoid_lut [SIG_DEPTH];
    neuron_outcome_t outcome_fifo [$];
    int              mismatch_count;

    // Sigmoid at each bin centre over [-8, 8), Q1.16
    function new();
      longint    c;
      longint    mag;
      longint    sum;
      bit [63:0] frac;
      bit [63:0] term;
      bit [63:0] r;
      bit [63:0] d;
      for (int i = 0; i < 4; i++) begin
        weight_q[i] = 0;
        grad_acc[i] = 0;
      end
      mismatch_count = 0;
      for (int i = 0; i < int'(SIG_DEPTH); i++) begin
        c = -(longint'(1) <<< 35) + ((longint'(2 * i + 1) <<< 35) / longint'(SIG_DEPTH));
        mag = (c < 0) ? -c : c;
        frac = 64'(mag) & 64'hFFFF_FFFF;
        // e^-frac by Taylor series
        term = 64'd1 << 32;
        sum = longint'(1) <<< 32;
        for (int k = 1; k <= 14; k++) begin
          term = ((term * frac) >> 32) / 64'(k);
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        if (sum > (longint'(1) <<< 32)) begin
          sum = longint'(1) <<< 32;
        end
        r = 64'(sum);
        // integer part: one product with e^-1 per unit
        for (longint k = 0; k < (mag >>> 32); k++) begin
          r = (r * EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
        end
        d = (64'd1 << 32) + r;
        r = ((64'd1 << 48) + (d >> 1)) / d;
        sigmoid_lut[i] = (c >= 0) ? r[16:0] : 17'(64'd65536 - r);
      end
    endfunction

    // Apply one accepted item to the shadow state and queue its outcome
    function void absorb_item(neuron_item_t it);
      longint          x [4];
      longint          z;
      longint          pred;
      longint          tgt;
      longint          err;
      longint          deriv;
      longint          delta;
      longint          sum;
      bit [63:0]       idx;
      neuron_outcome_t o;
      o = '0;
      x[0] = it.feature_0;
      x[1] = it.feature_1;
      x[2] = it.feature_2;
      x[3] = it.feature_3;
      if (it.opcode == OP_LOAD) begin
        if (it.weight_slot < FEATURES) begin
          weight_q[it.weight_slot] = it.weight_value;
        end
      end else if (it.opcode == OP_TRAIN || it.opcode == OP_INFER) begin
        // dot product in Q.28, clipped to [-8, 8)
        z = 0;
        for (int i = 0; i < int'(FEATURES); i++) begin
          z = z + weight_q[i] * x[i];
        end
        if (z > Z_HI) begin
          z = Z_HI;
        end
        if (z < Z_LO) begin
          z = Z_LO;
        end
        idx = (64'(z - Z_LO) * 64'(SIG_DEPTH)) >> 32;
        if (idx >= 64'(SIG_DEPTH)) begin
          idx = 64'(SIG_DEPTH) - 1;
        end
        pred = longint'(sigmoid_lut[idx]);
        o.prediction = 17'(pred);
        if (it.opcode == OP_TRAIN) begin
          tgt = (it.target > 17'h10000) ? 65536 : longint'(it.target);
          err = tgt - pred;
          deriv = (pred * (65536 - pred)) >>> 16;
          delta = (deriv * err) >>> 16;
          // gradient sums, saturating at 48 bits
          for (int i = 0; i < int'(FEATURES); i++) begin
            sum = grad_acc[i] + x[i] * delta;
            if (sum > ACC_HI) begin
              sum = ACC_HI;
            end
            if (sum < ACC_LO) begin
              sum = ACC_LO;
            end
            grad_acc[i] = sum;
          end
          // end of batch: fold sums into weights, saturating at 24 bits
          if (it.batch_last) begin
            for (int i = 0; i < int'(FEATURES); i++) begin
              sum = weight_q[i] + (grad_acc[i] >>> 12);
              if (sum > W_HI) begin
                sum = W_HI;
              end
              if (sum < W_LO) begin
                sum = W_LO;
              end
              weight_q[i] = sum;
              grad_acc[i] = 0;
            end
            o.applied = 1'b1;
          end
          o.residual = 18'(err);
        end
      end
      outcome_fifo = {outcome_fifo, o};
    endfunction

    function void flag(string field, longint exp_val, longint act_val);
      mismatch_count++;
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
    endfunction

    // Compare one result item with the oldest queued outcome
    function void compare_output(logic [16:0] prediction, logic signed [17:0] residual,
                                 logic applied);
      neuron_outcome_t e;
      if (outcome_fifo.size() == 0) begin
        mismatch_count++;
        $error("result with no item pending: prediction %0d residual %0d weights_applied %0b",
               prediction, residual, applied);
        return;
      end
      e = outcome_fifo.pop_front();
      if (prediction !== e.prediction) begin
        flag("prediction", longint'(e.prediction), longint'(prediction));
      end
      if (residual !== e.residual) begin
        flag("residual", longint'($signed(e.residual)), longint'(residual));
      end
      if (applied !== e.applied) begin
        flag("weights_applied", longint'(e.applied), longint'(applied));
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i       = OP_NONE;
  logic signed [15:0] feature_0_i    = '0;
  logic signed [15:0] feature_1_i    = '0;
  logic signed [15:0] feature_2_i    = '0;
  logic signed [15:0] feature_3_i    = '0;
  logic [16:0]        target_i       = '0;
  logic               batch_last_i   = 1'b0;
  logic [1:0]         weight_slot_i  = '0;
  logic signed [23:0] weight_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [16:0]        prediction_o;
  logic signed [17:0] residual_o;
  logic               weights_applied_o;

  neuron_mirror mirror = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  logistic_neuron_batch_trainer_unit #(
    .FEATURES           (FEATURES),
    .SIGMOID_TABLE_DEPTH(SIG_DEPTH)
  ) uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: check accepted results, then stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.compare_output(prediction_o, residual_o, weights_applied_o);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [15:0] rand_feature(bit wide);
    return wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
  endfunction

  function automatic logic signed [23:0] rand_weight(bit wide);
    return wide ? 24'($urandom) : 24'($urandom_range(0, 262143) - 131072);
  endfunction

  function automatic logic [16:0] rand_target();
    case ($urandom_range(3))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom);
    endcase
  endfunction

  // Any item with every field random
  function automatic neuron_item_t rand_item();
    neuron_item_t it;
    it.opcode       = 2'($urandom);
    it.feature_0    = 16'($urandom);
    it.feature_1    = 16'($urandom);
    it.feature_2    = 16'($urandom);
    it.feature_3    = 16'($urandom);
    it.target       = 17'($urandom);
    it.batch_last   = 1'($urandom);
    it.weight_slot  = 2'($urandom);
    it.weight_value = 24'($urandom);
    return it;
  endfunction

  // Present one item, hold it until accepted, then record it
  task automatic send_item(neuron_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    opcode_i       <= it.opcode;
    feature_0_i    <= it.feature_0;
    feature_1_i    <= it.feature_1;
    feature_2_i    <= it.feature_2;
    feature_3_i    <= it.feature_3;
    target_i       <= it.target;
    batch_last_i   <= it.batch_last;
    weight_slot_i  <= it.weight_slot;
    weight_value_i <= it.weight_value;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mirror.absorb_item(it);
    if (it.opcode != OP_NONE) begin
      items_sent++;
    end
  endtask

  task automatic send_load(logic [1:0] slot, logic signed [23:0] value, logic last);
    neuron_item_t it;
    it = rand_item();
    it.opcode       = OP_LOAD;
    it.weight_slot  = slot;
    it.weight_value = value;
    it.batch_last   = last;
    send_item(it);
  endtask

  task automatic send_sample(logic [1:0] op, logic signed [15:0] f0, logic signed [15:0] f1,
                             logic signed [15:0] f2, logic signed [15:0] f3,
                             logic [16:0] tgt, logic last);
    neuron_item_t it;
    it = rand_item();
    it.opcode     = op;
    it.feature_0  = f0;
    it.feature_1  = f1;
    it.feature_2  = f2;
    it.feature_3  = f3;
    it.target     = tgt;
    it.batch_last = last;
    send_item(it);
  endtask

  task automatic send_rand_sample(logic [1:0] op, logic last);
    bit wide;
    wide = ($urandom_range(99) < 20);
    send_sample(op, rand_feature(wide), rand_feature(wide), rand_feature(wide),
                rand_feature(wide), rand_target(), last);
  endtask

  // Mostly well-formed batches with random content, some noise and broken batches
  task automatic run_phase(int idle_pct, int stall_pct);
    int  start;
    int  roll;
    int  len;
    bit  wide;
    neuron_item_t it;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      roll = $urandom_range(99);
      wide = ($urandom_range(99) < 25);
      if (roll < 15) begin
        // reload some weights
        repeat ($urandom_range(1, 4)) begin
          send_load(2'($urandom), rand_weight(wide), 1'($urandom));
        end
      end else if (roll < 80) begin
        // training batch, now and then interrupted or left open
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 8) begin
            send_rand_sample(OP_INFER, 1'($urandom));
          end
          send_rand_sample(OP_TRAIN, (k == len - 1) && ($urandom_range(99) >= 5));
        end
      end else if (roll < 92) begin
        send_rand_sample(OP_INFER, 1'($urandom));
      end else begin
        it = rand_item();
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero weights, feature extremes, target limits, batch marks
    send_sample(OP_INFER, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 1'b1);
    send_sample(OP_INFER, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 17'h10000, 1'b0);
    send_sample(OP_TRAIN, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 17'h1FFFF, 1'b0);
    send_sample(OP_TRAIN, -16'sd32768, 16'sd32767, 16'sd0, 16'sd4096, 17'd0, 1'b1);
    send_sample(OP_NONE, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, 17'h10000, 1'b1);
    // weight extremes, batch mark on a load
    send_load(2'd0, 24'sh7FFFFF, 1'b1);
    send_load(2'd1, -24'sh800000, 1'b0);
    send_load(2'd2, 24'sd0, 1'b0);
    send_load(2'd3, 24'sd65536, 1'b1);
    // dot product clipped high and low
    send_sample(OP_INFER, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 17'd0, 1'b0);
    send_sample(OP_INFER, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 17'd0, 1'b0);
    // weight update that saturates high
    send_load(2'd3, 24'sd0, 1'b0);
    send_sample(OP_TRAIN, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 17'h10000, 1'b1);
    send_sample(OP_INFER, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 17'd0, 1'b0);
    // weight update that saturates low
    send_load(2'd0, -24'sh800000, 1'b0);
    send_load(2'd1, 24'sh7FFFFF, 1'b0);
    send_sample(OP_TRAIN, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 17'h10000, 1'b1);
    send_sample(OP_INFER, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 17'd0, 1'b0);

    // Random phases with different idling
    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(22, 22);
    in_valid_i <= 1'b0;

    while (mirror.outcome_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mirror.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
